// ===== sv/keyboard_boot_report_builder_core_assert.svh =====
// Assertion macros shared by the checker of the boot keyboard report builder.
// Each macro expects clk and rst_n in scope and reports through $error.
`ifndef KEYBOARD_BOOT_REPORT_BUILDER_CORE_ASSERT_SVH
`define KEYBOARD_BOOT_REPORT_BUILDER_CORE_ASSERT_SVH

// Same-cycle implication, quiet while reset is asserted.
`define KBR_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("kbr assertion failed: same-cycle implication");

// Next-cycle implication, quiet while reset is asserted.
`define KBR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("kbr assertion failed: next-cycle implication");

`endif

// ===== sv/kbr_pkg.sv =====
// Package of the boot keyboard report builder: payload types, constants,
// the key code to HID usage table and the modifier decoder. No dependencies.
`default_nettype none

package kbr_pkg;

  localparam int MAX_KEYS_DEF = 6;
  localparam int REPORT_SLOTS = 6;
  localparam int TABLE_LEN    = 128;

  typedef struct packed {
    logic [15:0] key_code;
    logic        is_press;
  } in_item_t;

  typedef struct packed {
    logic [7:0] modifier_byte;
    logic [7:0] slot_one;
    logic [7:0] slot_two;
    logic [7:0] slot_three;
    logic [7:0] slot_four;
    logic [7:0] slot_five;
    logic [7:0] slot_six;
    logic [2:0] held_count;
    logic       overflow;
  } out_item_t;

  // Token that walks down the cell chain with one key event.
  typedef struct packed {
    logic       valid;
    logic       press;
    logic       matched;  // press: already held; release: found and removed
    logic       placed;   // press: written into an empty cell
    logic [7:0] usage;
  } tok_t;

  function automatic logic [7:0] modifier_mask(input logic [15:0] code);
    logic [7:0] m;
    case (code)
      16'd29:  m = 8'h01;
      16'd42:  m = 8'h02;
      16'd56:  m = 8'h04;
      16'd125: m = 8'h08;
      16'd97:  m = 8'h10;
      16'd54:  m = 8'h20;
      16'd100: m = 8'h40;
      16'd126: m = 8'h80;
      default: m = 8'h00;
    endcase
    return m;
  endfunction

  function automatic logic [7:0] usage_of(input logic [6:0] code);
    logic [7:0] u;
    case (code)
      7'd1:   u = 8'd41;  7'd2:   u = 8'd30;  7'd3:   u = 8'd31;  7'd4:   u = 8'd32;
      7'd5:   u = 8'd33;  7'd6:   u = 8'd34;  7'd7:   u = 8'd35;  7'd8:   u = 8'd36;
      7'd9:   u = 8'd37;  7'd10:  u = 8'd38;  7'd11:  u = 8'd39;  7'd12:  u = 8'd45;
      7'd13:  u = 8'd46;  7'd14:  u = 8'd42;  7'd15:  u = 8'd43;  7'd16:  u = 8'd20;
      7'd17:  u = 8'd26;  7'd18:  u = 8'd8;   7'd19:  u = 8'd21;  7'd20:  u = 8'd23;
      7'd21:  u = 8'd28;  7'd22:  u = 8'd24;  7'd23:  u = 8'd12;  7'd24:  u = 8'd18;
      7'd25:  u = 8'd19;  7'd26:  u = 8'd47;  7'd27:  u = 8'd48;  7'd28:  u = 8'd40;
      7'd30:  u = 8'd4;   7'd31:  u = 8'd22;  7'd32:  u = 8'd7;   7'd33:  u = 8'd9;
      7'd34:  u = 8'd10;  7'd35:  u = 8'd11;  7'd36:  u = 8'd13;  7'd37:  u = 8'd14;
      7'd38:  u = 8'd15;  7'd39:  u = 8'd51;  7'd40:  u = 8'd52;  7'd41:  u = 8'd53;
      7'd43:  u = 8'd49;  7'd44:  u = 8'd29;  7'd45:  u = 8'd27;  7'd46:  u = 8'd6;
      7'd47:  u = 8'd25;  7'd48:  u = 8'd5;   7'd49:  u = 8'd17;  7'd50:  u = 8'd16;
      7'd51:  u = 8'd54;  7'd52:  u = 8'd55;  7'd53:  u = 8'd56;  7'd55:  u = 8'd85;
      7'd57:  u = 8'd44;  7'd58:  u = 8'd57;  7'd59:  u = 8'd58;  7'd60:  u = 8'd59;
      7'd61:  u = 8'd60;  7'd62:  u = 8'd61;  7'd63:  u = 8'd62;  7'd64:  u = 8'd63;
      7'd65:  u = 8'd64;  7'd66:  u = 8'd65;  7'd67:  u = 8'd66;  7'd68:  u = 8'd67;
      7'd69:  u = 8'd83;  7'd70:  u = 8'd71;  7'd71:  u = 8'd95;  7'd72:  u = 8'd96;
      7'd73:  u = 8'd97;  7'd74:  u = 8'd86;  7'd75:  u = 8'd92;  7'd76:  u = 8'd93;
      7'd77:  u = 8'd94;  7'd78:  u = 8'd87;  7'd79:  u = 8'd89;  7'd80:  u = 8'd90;
      7'd81:  u = 8'd91;  7'd82:  u = 8'd98;  7'd83:  u = 8'd99;  7'd87:  u = 8'd68;
      7'd88:  u = 8'd69;  7'd96:  u = 8'd88;  7'd98:  u = 8'd84;  7'd99:  u = 8'd70;
      7'd102: u = 8'd74;  7'd103: u = 8'd82;  7'd104: u = 8'd75;  7'd105: u = 8'd80;
      7'd106: u = 8'd79;  7'd107: u = 8'd77;  7'd108: u = 8'd81;  7'd109: u = 8'd78;
      7'd110: u = 8'd73;  7'd111: u = 8'd76;  7'd119: u = 8'd72;  7'd127: u = 8'd101;
      default: u = 8'd0;
    endcase
    return u;
  endfunction

endpackage

`default_nettype wire

// ===== sv/kbr_cell.sv =====
// One slot of the held-key list. It acts on the token from its left neighbor
// and passes it on through its token register. Depends on kbr_pkg.
`default_nettype none

module kbr_cell (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire kbr_pkg::tok_t tok_in,
  input  wire logic [7:0]    nbr_key,
  input  wire logic          nbr_occ,
  output logic [7:0]         key,
  output logic               occ,
  output kbr_pkg::tok_t      tok_out
);

  logic [7:0]    key_r, key_nxt;
  logic          occ_r, occ_nxt;
  kbr_pkg::tok_t tok_r, tok_nxt;
  logic          hit;

  assign hit = occ_r && (key_r == tok_in.usage);

  always_comb begin
    key_nxt = key_r;
    occ_nxt = occ_r;
    tok_nxt = tok_in;
    if (tok_in.valid) begin
      if (tok_in.press) begin
        if (!tok_in.matched && !tok_in.placed) begin
          if (hit) begin
            tok_nxt.matched = 1'b1;
          end else if (!occ_r) begin
            // The list is packed, so the first empty cell ends the search.
            key_nxt         = tok_in.usage;
            occ_nxt         = 1'b1;
            tok_nxt.placed  = 1'b1;
          end
        end
      end else if (tok_in.matched || hit) begin
        // From the removed key onward every cell takes its right neighbor.
        key_nxt         = nbr_key;
        occ_nxt         = nbr_occ;
        tok_nxt.matched = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r       <= 8'd0;
      occ_r       <= 1'b0;
      tok_r       <= '0;
    end else begin
      key_r       <= key_nxt;
      occ_r       <= occ_nxt;
      tok_r       <= tok_nxt;
    end
  end

  assign key     = key_r;
  assign occ     = occ_r;
  assign tok_out = tok_r;

endmodule

`default_nettype wire

// ===== sv/keyboard_boot_report_builder_core.sv =====
// Boot keyboard report builder. A mapped key event walks the chain of MAX_KEYS
// cells, one cell per cycle, and its result is then loaded into the output
// register; modifier and unmapped events go straight to the output register.
// The next event is accepted the cycle after the result is loaded; no event is
// taken before the last one is through, and none while out_stall holds it.
// Synchronous active-low reset empties the list and clears modifiers and count.
`default_nettype none

module keyboard_boot_report_builder_core #(
  parameter int MAX_KEYS = kbr_pkg::MAX_KEYS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire kbr_pkg::in_item_t in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output kbr_pkg::out_item_t     out_data
);

  localparam int CW = $clog2(MAX_KEYS + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_REPORT
  } state_t;

  state_t             state_r, state_nxt;
  logic [7:0]         mod_r, mod_nxt;
  logic [CW-1:0]      cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  kbr_pkg::tok_t      launch_r, launch_nxt;
  logic               out_valid_r, out_valid_nxt;
  kbr_pkg::out_item_t out_data_r, out_data_nxt;

  kbr_pkg::tok_t      tok_w [MAX_KEYS+1];
  logic [7:0]         key_w [MAX_KEYS+1];
  logic               occ_w [MAX_KEYS+1];
  logic [7:0]         slot_v [kbr_pkg::REPORT_SLOTS];
  logic [CW+2:0]      cnt_ext;

  logic               in_fire;
  logic [7:0]         mask;
  logic [7:0]         usage;
  logic               mapped;
  kbr_pkg::tok_t      tok_end;

  assign tok_w[0]        = launch_r;
  assign key_w[MAX_KEYS] = 8'd0;
  assign occ_w[MAX_KEYS] = 1'b0;
  assign tok_end         = tok_w[MAX_KEYS];

  for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
    kbr_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .tok_in  (tok_w[i]),
      .nbr_key (key_w[i+1]),
      .nbr_occ (occ_w[i+1]),
      .key     (key_w[i]),
      .occ     (occ_w[i]),
      .tok_out (tok_w[i+1])
    );
  end

  for (genvar s = 0; s < kbr_pkg::REPORT_SLOTS; s++) begin : g_slot
    if (s < MAX_KEYS) begin : g_live
      assign slot_v[s] = occ_w[s] ? key_w[s] : 8'd0;
    end else begin : g_none
      assign slot_v[s] = 8'd0;
    end
  end

  assign cnt_ext  = {3'b000, cnt_r};
  assign in_stall = (state_r != S_IDLE);
  assign in_fire  = in_valid && !in_stall;
  assign mask     = kbr_pkg::modifier_mask(in_data.key_code);
  assign usage    = kbr_pkg::usage_of(in_data.key_code[6:0]);
  assign mapped   = (mask == 8'd0) && (in_data.key_code[15:7] == 9'd0) && (usage != 8'd0);

  always_comb begin
    state_nxt     = state_r;
    mod_nxt       = mod_r;
    cnt_nxt       = cnt_r;
    ovf_nxt       = ovf_r;
    launch_nxt    = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          ovf_nxt = 1'b0;
          if (mask != 8'd0) begin
            mod_nxt   = in_data.is_press ? (mod_r | mask) : (mod_r & ~mask);
            state_nxt = S_REPORT;
          end else if (mapped) begin
            launch_nxt.valid = 1'b1;
            launch_nxt.press = in_data.is_press;
            launch_nxt.usage = usage;
            state_nxt        = S_WALK;
          end else begin
            state_nxt = S_REPORT;
          end
        end
      end
      S_WALK: begin
        if (tok_end.valid) begin
          if (tok_end.press) begin
            if (tok_end.placed) begin
              cnt_nxt = cnt_r + CW'(1);
            end
            ovf_nxt = !tok_end.matched && !tok_end.placed;
          end else if (tok_end.matched) begin
            cnt_nxt = cnt_r - CW'(1);
          end
          state_nxt = S_REPORT;
        end
      end
      S_REPORT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt               = 1'b1;
          out_data_nxt.modifier_byte  = mod_r;
          out_data_nxt.slot_one       = slot_v[0];
          out_data_nxt.slot_two       = slot_v[1];
          out_data_nxt.slot_three     = slot_v[2];
          out_data_nxt.slot_four      = slot_v[3];
          out_data_nxt.slot_five      = slot_v[4];
          out_data_nxt.slot_six       = slot_v[5];
          out_data_nxt.held_count     = cnt_ext[2:0];
          out_data_nxt.overflow       = ovf_r;
          state_nxt                   = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      mod_r       <= 8'd0;
      cnt_r       <= '0;
      ovf_r       <= 1'b0;
      launch_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mod_r       <= mod_nxt;
      cnt_r       <= cnt_nxt;
      ovf_r       <= ovf_nxt;
      launch_r    <= launch_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

// ===== sv/kbr_checker.sv =====
// Port-level checks for the boot keyboard report builder, bound to the top.
// Depends on kbr_pkg and the assertion macro header.
`default_nettype none

`include "keyboard_boot_report_builder_core_assert.svh"

module kbr_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_stall,
  input wire logic               out_valid,
  input wire logic               out_stall,
  input wire kbr_pkg::out_item_t out_data
);

  // A stalled result transaction holds its valid and payload.
  `KBR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // Events are handled one at a time, so an accepted event blocks the next cycle.
  `KBR_ASSERT_NEXT(a_one_at_a_time, in_valid && !in_stall, in_stall)

  // An overflow can only be reported while the list is full, hence not empty.
  `KBR_ASSERT_IMPL(a_ovf_nonempty, out_valid && out_data.overflow, out_data.slot_one != 8'd0)

  // The list is packed: an empty first slot means nothing is held.
  `KBR_ASSERT_IMPL(a_packed, out_valid && (out_data.slot_one == 8'd0), (out_data.held_count == 3'd0) && (out_data.slot_two == 8'd0))

endmodule

bind keyboard_boot_report_builder_core kbr_checker u_kbr_checker (.*);

`default_nettype wire
